// ----- src/zbr_pkg.sv -----
// Shared types and constants for the z-buffer triangle rasterizer.
// No dependencies; every other file imports this package.
package zbr_pkg;

    localparam int MAX_PIXELS = 262144;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_BITS = 12;

    localparam int PIX_W     = 11;
    localparam int DEPTH_W   = 32;
    localparam int SHADE_W   = 8;
    localparam int IDX_OUT_W = 20;
    localparam int COLOR_W   = 32;
    localparam int ADDR_W    = $clog2(MAX_PIXELS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int DIFF_W    = COORD_BITS + 2;
    localparam int EDGE_W    = 2 * DIFF_W + 1;
    localparam int MAG_W     = EDGE_W - 1 + FRAC_BITS;
    localparam int QUO_W     = MAG_W + 1;
    localparam int WT_W      = FRAC_BITS + 2;
    localparam int ACC_W     = DEPTH_W + WT_W + 2;
    localparam int BOX_W     = ((COORD_BITS > PIX_W) ? COORD_BITS : PIX_W) + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR_DEPTH    = 2'd2;

    localparam logic [PIX_W-1:0]          RST_FRAME_WIDTH  = 11'd480;
    localparam logic [PIX_W-1:0]          RST_FRAME_HEIGHT = 11'd272;
    localparam logic signed [DEPTH_W-1:0] RST_FAR_DEPTH    = 32'sd655360000;
    localparam logic [7:0]                ALPHA            = 8'hFF;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_LOAD,
        S_EDGE,
        S_DIV,
        S_MUL,
        S_CMP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]                   opcode;
        logic signed [COORD_BITS-1:0] vert0_x;
        logic signed [COORD_BITS-1:0] vert0_y;
        logic signed [DEPTH_W-1:0]    vert0_depth;
        logic signed [COORD_BITS-1:0] vert1_x;
        logic signed [COORD_BITS-1:0] vert1_y;
        logic signed [DEPTH_W-1:0]    vert1_depth;
        logic signed [COORD_BITS-1:0] vert2_x;
        logic signed [COORD_BITS-1:0] vert2_y;
        logic signed [DEPTH_W-1:0]    vert2_depth;
        logic [SHADE_W-1:0]           shade_level;
    } t_in_item;

    typedef struct packed {
        logic                 write_valid;
        logic [IDX_OUT_W-1:0] pixel_index;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 done_res;
    } t_out_item;

endpackage

// ----- src/zbr_div.sv -----
// Iterative signed divider, one quotient bit per cycle, truncation toward zero.
// Divides (edge value << FRAC_BITS) by the triangle area. Uses zbr_pkg.
module zbr_div import zbr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [EDGE_W-1:0] i_num,
    input  logic signed [EDGE_W-1:0] i_den,
    output logic                     o_done,
    output logic signed [QUO_W-1:0]  o_quo
);

    localparam int DCNT_W = $clog2(MAG_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [MAG_W-1:0]  r_num;
    logic [EDGE_W-2:0] r_rem;
    logic [EDGE_W-2:0] r_den;
    logic              r_neg;

    logic [EDGE_W-1:0] num_abs;
    logic [EDGE_W-1:0] den_abs;
    logic [EDGE_W-1:0] rem_sh;
    logic [EDGE_W-1:0] rem_sub;
    logic              ge;

    always_comb begin
        num_abs = i_num[EDGE_W-1] ? -i_num : i_num;
        den_abs = i_den[EDGE_W-1] ? -i_den : i_den;
        rem_sh  = {r_rem, r_num[MAG_W-1]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= DCNT_W'(MAG_W);
            r_num <= {num_abs[EDGE_W-2:0], {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= den_abs[EDGE_W-2:0];
            r_neg <= i_num[EDGE_W-1] ^ i_den[EDGE_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - DCNT_W'(1);
            r_num <= {r_num[MAG_W-2:0], ge};
            r_rem <= ge ? rem_sub[EDGE_W-2:0] : rem_sh[EDGE_W-2:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});

endmodule

// ----- src/zbuffer_triangle_rasterizer.sv -----
// Top level of the z-buffer triangle rasterizer: control FSM and depth store.
// Uses zbr_pkg and zbr_div.
//
// One item is taken at a time. A clear sweeps min(frame_width*frame_height,
// MAX_PIXELS) depth entries at one per cycle; a load runs through S_LOAD; a
// step with no active triangle goes straight to S_FIN; a step on an active
// triangle runs S_EDGE, S_DIV, S_MUL, S_CMP and S_FIN when the pixel lies
// inside the triangle and the frame: the bit-serial weight dividers, the
// shared multiplier and a read-modify-write of the depth store. When it is
// rejected after the divide it goes from S_DIV to S_FIN. A stalled result
// holds a step in S_FIN. The depth store holds garbage after reset until a
// clear has run. The result register lets the next item in while a result
// waits.
module zbuffer_triangle_rasterizer import zbr_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic signed [QUO_W+1:0] W_ONE = (QUO_W+2)'(1) << FRAC_BITS;

    t_state r_state, n_state;

    logic [PIX_W-1:0]             r_fw, r_fh;
    logic signed [DEPTH_W-1:0]    r_far;
    logic signed [COORD_BITS-1:0] r_vx [3];
    logic signed [COORD_BITS-1:0] r_vy [3];
    logic signed [DEPTH_W-1:0]    r_vz [3];
    logic [SHADE_W-1:0]           r_shade;
    logic signed [EDGE_W-1:0]     r_area;
    logic [PIX_W-1:0]             r_lo_c, r_hi_c, r_hi_r, r_col, r_row;
    logic                         r_active;
    logic [CNT_W-1:0]             r_clr_cnt, r_clr_n;
    logic [ADDR_W-1:0]            r_idx;
    logic                         r_idx_ok;
    logic signed [WT_W-1:0]       r_w [3];
    logic [1:0]                   r_mul;
    logic signed [ACC_W-1:0]      r_acc;
    logic [DEPTH_W-1:0]           r_rd_data;
    logic                         r_hit;
    logic                         r_out_valid;
    t_out_item                    r_out;

    logic [DEPTH_W-1:0] mem [MAX_PIXELS];

    logic                          in_beat;
    logic                          out_free;
    logic [2*PIX_W-1:0]            clr_prod;
    logic [CNT_W-1:0]              clr_n;
    logic signed [BOX_W-1:0]       bx [3];
    logic signed [BOX_W-1:0]       by [3];
    logic signed [BOX_W-1:0]       lo_c, hi_c, lo_r, hi_r, fw_m1, fh_m1;
    logic signed [DIFF_W-1:0]      ax1, ay1, ax2, ay2;
    logic signed [2*DIFF_W-1:0]    ap_a, ap_b;
    logic signed [EDGE_W-1:0]      area;
    logic signed [DIFF_W-1:0]      px, py;
    logic signed [DIFF_W-1:0]      dx [3];
    logic signed [DIFF_W-1:0]      dy [3];
    logic signed [2*DIFF_W-1:0]    p0a, p0b, p1a, p1b;
    logic signed [EDGE_W-1:0]      e0, e1;
    logic [2*PIX_W:0]              idx_full;
    logic                          div_start, div_done, div_done1;
    logic signed [QUO_W-1:0]       q0, q1;
    logic signed [QUO_W+1:0]       w2;
    logic                          pass;
    logic signed [DEPTH_W+WT_W-1:0] prod;
    logic signed [ACC_W-1:0]       z;
    logic signed [ACC_W-1:0]       stored;
    logic                          nearer;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [DEPTH_W-1:0]            mem_wdata;
    logic                          mem_re;
    logic                          nx_active;
    logic [PIX_W-1:0]              nx_col, nx_row;

    assign in_beat  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        // clear length
        clr_prod = r_fw * r_fh;
        clr_n    = ({1'b0, clr_prod} > (2*PIX_W+1)'(MAX_PIXELS)) ?
                   CNT_W'(MAX_PIXELS) : clr_prod[CNT_W-1:0];

        // load: clipped box and signed area
        for (int k = 0; k < 3; k++) begin
            bx[k] = BOX_W'(r_vx[k]);
            by[k] = BOX_W'(r_vy[k]);
        end
        fw_m1 = $signed({{(BOX_W-PIX_W){1'b0}}, r_fw}) - BOX_W'(1);
        fh_m1 = $signed({{(BOX_W-PIX_W){1'b0}}, r_fh}) - BOX_W'(1);
        lo_c = (bx[0] < bx[1]) ? bx[0] : bx[1];
        lo_c = (lo_c < bx[2]) ? lo_c : bx[2];
        hi_c = (bx[0] > bx[1]) ? bx[0] : bx[1];
        hi_c = (hi_c > bx[2]) ? hi_c : bx[2];
        lo_r = (by[0] < by[1]) ? by[0] : by[1];
        lo_r = (lo_r < by[2]) ? lo_r : by[2];
        hi_r = (by[0] > by[1]) ? by[0] : by[1];
        hi_r = (hi_r > by[2]) ? hi_r : by[2];
        if (lo_c < 0) lo_c = '0;
        if (lo_r < 0) lo_r = '0;
        if (hi_c > fw_m1) hi_c = fw_m1;
        if (hi_r > fh_m1) hi_r = fh_m1;

        ax1  = DIFF_W'(r_vx[1]) - DIFF_W'(r_vx[0]);
        ay1  = DIFF_W'(r_vy[1]) - DIFF_W'(r_vy[0]);
        ax2  = DIFF_W'(r_vx[2]) - DIFF_W'(r_vx[0]);
        ay2  = DIFF_W'(r_vy[2]) - DIFF_W'(r_vy[0]);
        ap_a = ax1 * ay2;
        ap_b = ay1 * ax2;
        area = {ap_a[2*DIFF_W-1], ap_a} - {ap_b[2*DIFF_W-1], ap_b};

        // edge values at the current pixel
        px = $signed({{(DIFF_W-PIX_W){1'b0}}, r_col});
        py = $signed({{(DIFF_W-PIX_W){1'b0}}, r_row});
        for (int k = 0; k < 3; k++) begin
            dx[k] = DIFF_W'(r_vx[k]) - px;
            dy[k] = DIFF_W'(r_vy[k]) - py;
        end
        p0a = dx[1] * dy[2];
        p0b = dy[1] * dx[2];
        p1a = dx[2] * dy[0];
        p1b = dy[2] * dx[0];
        e0  = {p0a[2*DIFF_W-1], p0a} - {p0b[2*DIFF_W-1], p0b};
        e1  = {p1a[2*DIFF_W-1], p1a} - {p1b[2*DIFF_W-1], p1b};
        idx_full = ({{(PIX_W+1){1'b0}}, r_row} * {{(PIX_W+1){1'b0}}, r_fw}) +
                   (2*PIX_W+1)'(r_col);

        // weights
        w2   = W_ONE - (QUO_W+2)'(q0) - (QUO_W+2)'(q1);
        pass = !q0[QUO_W-1] && !q1[QUO_W-1] && !w2[QUO_W+1] && r_idx_ok;

        // depth
        prod   = r_vz[r_mul] * r_w[r_mul];
        z      = r_acc >>> FRAC_BITS;
        stored = ACC_W'($signed(r_rd_data));
        nearer = z < stored;

        // raster advance
        nx_active = r_active;
        nx_col    = r_col;
        nx_row    = r_row;
        if (r_active) begin
            if (r_col < r_hi_c) begin
                nx_col = r_col + PIX_W'(1);
            end else if (r_row < r_hi_r) begin
                nx_col = r_lo_c;
                nx_row = r_row + PIX_W'(1);
            end else begin
                nx_active = 1'b0;
            end
        end
    end

    assign div_start = (r_state == S_EDGE);

    zbr_div u_div0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (e0),
        .i_den   (r_area),
        .o_done  (div_done),
        .o_quo   (q0)
    );

    zbr_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (e1),
        .i_den   (r_area),
        .o_done  (div_done1),
        .o_quo   (q1)
    );

    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = z[DEPTH_W-1:0];
        mem_re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    case (i_in_data.opcode)
                        OP_CLEAR: n_state = (clr_n != '0) ? S_CLEAR : S_IDLE;
                        OP_LOAD:  n_state = S_LOAD;
                        OP_STEP:  n_state = r_active ? S_EDGE : S_FIN;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt[ADDR_W-1:0];
                mem_wdata = r_far;
                if (r_clr_cnt + CNT_W'(1) == r_clr_n) n_state = S_IDLE;
            end
            S_LOAD: n_state = S_IDLE;
            S_EDGE: n_state = S_DIV;
            S_DIV: begin
                if (div_done && div_done1) n_state = pass ? S_MUL : S_FIN;
            end
            S_MUL: begin
                mem_re = (r_mul == 2'd0);
                if (r_mul == 2'd2) n_state = S_CMP;
            end
            S_CMP: begin
                mem_we  = nearer;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_fw        <= RST_FRAME_WIDTH;
            r_fh        <= RST_FRAME_HEIGHT;
            r_far       <= RST_FAR_DEPTH;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_fw  <= i_cfg_data[PIX_W-1:0];
                    CFG_FRAME_HEIGHT: r_fh  <= i_cfg_data[PIX_W-1:0];
                    CFG_FAR_DEPTH:    r_far <= i_cfg_data[DEPTH_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_LOAD) begin
                r_active <= (area != '0) && (lo_c <= hi_c) && (lo_r <= hi_r);
            end else if (r_state == S_FIN && out_free) begin
                r_active <= nx_active;
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_clr_cnt <= '0;
            r_clr_n   <= clr_n;
            r_hit     <= 1'b0;
        end
        // triangle regs change only on a load; steps keep using them
        if (in_beat && i_in_data.opcode == OP_LOAD) begin
            r_vx[0] <= i_in_data.vert0_x;
            r_vy[0] <= i_in_data.vert0_y;
            r_vz[0] <= i_in_data.vert0_depth;
            r_vx[1] <= i_in_data.vert1_x;
            r_vy[1] <= i_in_data.vert1_y;
            r_vz[1] <= i_in_data.vert1_depth;
            r_vx[2] <= i_in_data.vert2_x;
            r_vy[2] <= i_in_data.vert2_y;
            r_vz[2] <= i_in_data.vert2_depth;
            r_shade <= i_in_data.shade_level;
        end
        if (r_state == S_CLEAR) r_clr_cnt <= r_clr_cnt + CNT_W'(1);
        if (r_state == S_LOAD) begin
            r_area <= area;
            r_lo_c <= lo_c[PIX_W-1:0];
            r_hi_c <= hi_c[PIX_W-1:0];
            r_hi_r <= hi_r[PIX_W-1:0];
            r_col  <= lo_c[PIX_W-1:0];
            r_row  <= lo_r[PIX_W-1:0];
        end
        if (r_state == S_EDGE) begin
            r_idx    <= idx_full[ADDR_W-1:0];
            r_idx_ok <= (r_col < r_fw) && (r_row < r_fh) &&
                        (idx_full < (2*PIX_W+1)'(MAX_PIXELS));
            r_mul    <= 2'd0;
        end
        if (r_state == S_DIV) begin
            r_w[0] <= q0[WT_W-1:0];
            r_w[1] <= q1[WT_W-1:0];
            r_w[2] <= w2[WT_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_mul <= r_mul + 2'd1;
            r_acc <= ((r_mul == 2'd0) ? '0 : r_acc) + ACC_W'(prod);
        end
        if (r_state == S_CMP) r_hit <= nearer;
        if (r_state == S_FIN && out_free) begin
            r_col                   <= nx_col;
            r_row                   <= nx_row;
            r_out.write_valid       <= r_hit;
            r_out.pixel_index       <= r_hit ? IDX_OUT_W'(r_idx) : '0;
            r_out.pixel_color       <= r_hit ? {ALPHA, r_shade, r_shade, r_shade} : '0;
            r_out.done_res          <= !nx_active;
        end
    end

    // depth store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= mem[r_idx];
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- src/zbr_checker.sv -----
// Port-level checks for the z-buffer triangle rasterizer, bound to the top.
// Uses zbr_pkg.
module zbr_checker import zbr_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input t_in_item             i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_data,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [CFG_W-1:0]     i_cfg_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.opcode != OP_STEP
        |=> !$rose(o_out_valid))
        else $error("result after clear or load");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.write_valid
        |-> o_out_data.pixel_index == '0 && o_out_data.pixel_color == '0)
        else $error("non-write beat carries data");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_valid
        |-> o_out_data.pixel_color[31:24] == ALPHA &&
            o_out_data.pixel_color[23:16] == o_out_data.pixel_color[7:0] &&
            o_out_data.pixel_color[15:8] == o_out_data.pixel_color[7:0])
        else $error("color not opaque grey");

endmodule

bind zbuffer_triangle_rasterizer zbr_checker u_zbr_checker (.*);
